FILE: design/spi_pkg.sv
// Package for segment_plane_intersect: operand widths, pipeline depth and the
// sideband record carried through the divider. No dependencies.
package spi_pkg;

   localparam int unsigned CW    = 32;                  // coordinate width
   localparam int unsigned DFW   = CW + 1;              // difference width
   localparam int unsigned PW    = CW + DFW;            // dot term width
   localparam int unsigned NUMW  = PW + 2;              // dot product width
   localparam int unsigned MAGW  = NUMW - 1;            // magnitude width
   localparam int unsigned CHW   = (MAGW + 2) / 3;      // multiplier chunk
   localparam int unsigned PPW   = CW + CHW;            // partial product
   localparam int unsigned PRODW = CW + 3 * CHW;        // |d| * |num|
   localparam int unsigned NW    = PRODW + 2;           // dividend
   localparam int unsigned D2W   = MAGW + 1;            // divisor (2 * |den|)
   localparam int unsigned QW    = CW + 1;              // quotient bits
   localparam int unsigned RW    = CW + 3;              // sum before clamp
   localparam int unsigned PRE_STAGES = 8;
   localparam int unsigned LATENCY    = PRE_STAGES + QW + 1;

   typedef struct packed {
      logic                 hit;
      logic [2:0]           dneg;
      logic [2:0][CW-1:0]   s;
   } side_type;

endpackage

FILE: design/spi_div.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes that
// share one divisor. Depends on spi_pkg.
module spi_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic [2:0][spi_pkg::NW-1:0]            in_num,
   input  logic [spi_pkg::D2W-1:0]                in_den,
   input  spi_pkg::side_type                      in_side,
   output logic                                   out_valid,
   output logic [2:0][spi_pkg::QW-1:0]            out_quo,
   output spi_pkg::side_type                      out_side
);

   logic [spi_pkg::QW-1:0]               vld_ff;
   logic [2:0][spi_pkg::NW-1:0]          rem_ff  [spi_pkg::QW];
   logic [2:0][spi_pkg::NW-1:0]          rem_in  [spi_pkg::QW];
   logic [2:0][spi_pkg::QW-1:0]          quo_ff  [spi_pkg::QW];
   logic [2:0][spi_pkg::QW-1:0]          quo_in  [spi_pkg::QW];
   logic [spi_pkg::D2W-1:0]              den_ff  [spi_pkg::QW];
   spi_pkg::side_type                    side_ff [spi_pkg::QW];

   for (genvar j = 0; j < spi_pkg::QW; j++) begin : g_stage
      localparam int unsigned BIT = spi_pkg::QW - 1 - j;
      logic                          prev_vld;
      logic [2:0][spi_pkg::NW-1:0]   prev_rem;
      logic [2:0][spi_pkg::QW-1:0]   prev_quo;
      logic [spi_pkg::D2W-1:0]       prev_den;
      spi_pkg::side_type             prev_side;
      logic [spi_pkg::NW-1:0]        shifted;

      if (j == 0) begin : g_first
         assign prev_vld  = in_valid;
         assign prev_rem  = in_num;
         assign prev_quo  = '0;
         assign prev_den  = in_den;
         assign prev_side = in_side;
      end else begin : g_next
         assign prev_vld  = vld_ff[j-1];
         assign prev_rem  = rem_ff[j-1];
         assign prev_quo  = quo_ff[j-1];
         assign prev_den  = den_ff[j-1];
         assign prev_side = side_ff[j-1];
      end

      assign shifted = spi_pkg::NW'(prev_den) << BIT;

      always_comb begin
         for (int k = 0; k < 3; k++) begin
            if (prev_rem[k] >= shifted) begin
               rem_in[j][k] = prev_rem[k] - shifted;
               quo_in[j][k] = prev_quo[k] | (spi_pkg::QW'(1) << BIT);
            end else begin
               rem_in[j][k] = prev_rem[k];
               quo_in[j][k] = prev_quo[k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j]  <= rem_in[j];
         quo_ff[j]  <= quo_in[j];
         den_ff[j]  <= prev_den;
         side_ff[j] <= prev_side;
      end
   end

   assign out_valid = vld_ff[spi_pkg::QW-1];
   assign out_quo   = quo_ff[spi_pkg::QW-1];
   assign out_side  = side_ff[spi_pkg::QW-1];

endmodule

FILE: design/segment_plane_intersect.sv
// rsp_strobe rises once an accepted request has passed stages A to H, the
// divider and the output register; throughput one item per cycle, set by the
// fully pipelined 33-stage divider.
// busy stays low; the result pulse cannot be stalled by the receiver.
// Synchronous active-high reset empties the pipeline; in-flight items are dropped.
// Depends on spi_pkg and spi_div.
module segment_plane_intersect (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_start_x,
   input  logic [31:0] req_start_y,
   input  logic [31:0] req_start_z,
   input  logic [31:0] req_end_x,
   input  logic [31:0] req_end_y,
   input  logic [31:0] req_end_z,
   input  logic [31:0] req_normal_x,
   input  logic [31:0] req_normal_y,
   input  logic [31:0] req_normal_z,
   input  logic [31:0] req_plane_x,
   input  logic [31:0] req_plane_y,
   input  logic [31:0] req_plane_z,
   output logic        rsp_strobe,
   output logic        rsp_hit,
   output logic [31:0] rsp_point_x,
   output logic [31:0] rsp_point_y,
   output logic [31:0] rsp_point_z
);

   localparam int unsigned CW = spi_pkg::CW;

   logic signed [CW-1:0]  sx_in [3];
   logic signed [CW-1:0]  ex_in [3];
   logic signed [CW-1:0]  nx_in [3];
   logic signed [CW-1:0]  px_in [3];

   // stage A
   logic                          a_vld_ff;
   logic signed [CW-1:0]          a_s_ff [3];
   logic signed [spi_pkg::DFW-1:0] a_d_ff [3];
   logic signed [spi_pkg::DFW-1:0] a_w_ff [3];
   logic signed [CW-1:0]          a_n_ff [3];
   // stage B
   logic                          b_vld_ff;
   logic signed [CW-1:0]          b_s_ff [3];
   logic signed [spi_pkg::DFW-1:0] b_d_ff [3];
   logic signed [spi_pkg::PW-1:0] b_pn_ff [3];
   logic signed [spi_pkg::PW-1:0] b_pd_ff [3];
   // stage C
   logic                            c_vld_ff;
   logic signed [CW-1:0]            c_s_ff [3];
   logic signed [spi_pkg::DFW-1:0]  c_d_ff [3];
   logic signed [spi_pkg::NUMW-1:0] c_num_ff;
   logic signed [spi_pkg::NUMW-1:0] c_den_ff;
   // stage D
   logic                          d_vld_ff;
   logic [2:0][CW-1:0]            d_s_ff;
   logic [CW-1:0]                 d_dmag_ff [3];
   logic [2:0]                    d_dneg_ff;
   logic [spi_pkg::MAGW-1:0]      d_an_ff;
   logic [spi_pkg::MAGW-1:0]      d_ad_ff;
   logic                          d_nneg_ff, d_dnz_ff, d_nzero_ff, d_dzero_ff;
   logic signed [spi_pkg::NUMW-1:0] neg_num, neg_den;
   // stage E
   logic                          e_vld_ff, e_hit_ff;
   logic [2:0][CW-1:0]            e_s_ff;
   logic [CW-1:0]                 e_dmag_ff [3];
   logic [2:0]                    e_dneg_ff;
   logic [spi_pkg::MAGW-1:0]      e_an_ff;
   logic [spi_pkg::MAGW-1:0]      e_ad_ff;
   // stage F
   logic                          f_vld_ff;
   spi_pkg::side_type             f_side_ff;
   logic [spi_pkg::MAGW-1:0]      f_ad_ff;
   logic [spi_pkg::PPW-1:0]       f_pp_ff [3][3];
   logic [3*spi_pkg::CHW-1:0]     an_pad;
   // stage G
   logic                          g_vld_ff;
   spi_pkg::side_type             g_side_ff;
   logic [spi_pkg::MAGW-1:0]      g_ad_ff;
   logic [spi_pkg::PRODW-1:0]     g_prod_ff [3];
   // stage H
   logic                          h_vld_ff;
   spi_pkg::side_type             h_side_ff;
   logic [spi_pkg::D2W-1:0]       h_den_ff;
   logic [2:0][spi_pkg::NW-1:0]   h_num_ff;
   // divider and output
   logic                          q_vld;
   logic [2:0][spi_pkg::QW-1:0]   q_quo;
   spi_pkg::side_type             q_side;
   logic [2:0][CW-1:0]            point_in;
   logic [2:0][CW-1:0]            point_ff;
   logic                          strobe_ff, hit_ff;

   assign busy = 1'b0;

   assign sx_in[0] = req_start_x;  assign sx_in[1] = req_start_y;  assign sx_in[2] = req_start_z;
   assign ex_in[0] = req_end_x;    assign ex_in[1] = req_end_y;    assign ex_in[2] = req_end_z;
   assign nx_in[0] = req_normal_x; assign nx_in[1] = req_normal_y; assign nx_in[2] = req_normal_z;
   assign px_in[0] = req_plane_x;  assign px_in[1] = req_plane_y;  assign px_in[2] = req_plane_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0; b_vld_ff <= 1'b0; c_vld_ff <= 1'b0; d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0; f_vld_ff <= 1'b0; g_vld_ff <= 1'b0; h_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start & ~busy;
         b_vld_ff <= a_vld_ff; c_vld_ff <= b_vld_ff; d_vld_ff <= c_vld_ff;
         e_vld_ff <= d_vld_ff; f_vld_ff <= e_vld_ff; g_vld_ff <= f_vld_ff;
         h_vld_ff <= g_vld_ff;
      end
   end

   assign neg_num = -c_num_ff;
   assign neg_den = -c_den_ff;
   assign an_pad  = (3*spi_pkg::CHW)'(e_an_ff);

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         // A: differences
         a_s_ff[k] <= sx_in[k];
         a_n_ff[k] <= nx_in[k];
         a_d_ff[k] <= spi_pkg::DFW'(ex_in[k]) - spi_pkg::DFW'(sx_in[k]);
         a_w_ff[k] <= spi_pkg::DFW'(px_in[k]) - spi_pkg::DFW'(sx_in[k]);
         // B: dot terms
         b_s_ff[k]  <= a_s_ff[k];
         b_d_ff[k]  <= a_d_ff[k];
         b_pn_ff[k] <= spi_pkg::PW'(a_n_ff[k]) * spi_pkg::PW'(a_w_ff[k]);
         b_pd_ff[k] <= spi_pkg::PW'(a_n_ff[k]) * spi_pkg::PW'(a_d_ff[k]);
         // C
         c_s_ff[k] <= b_s_ff[k];
         c_d_ff[k] <= b_d_ff[k];
         // D: magnitudes
         d_s_ff[k]    <= c_s_ff[k];
         d_dneg_ff[k] <= c_d_ff[k][spi_pkg::DFW-1];
         d_dmag_ff[k] <= c_d_ff[k][spi_pkg::DFW-1] ? CW'(-c_d_ff[k]) : CW'(c_d_ff[k]);
         // E
         e_s_ff[k]    <= d_s_ff[k];
         e_dmag_ff[k] <= d_dmag_ff[k];
         e_dneg_ff[k] <= d_dneg_ff[k];
         // F: partial products of |d| * |num|
         for (int c = 0; c < 3; c++) begin
            f_pp_ff[k][c] <= spi_pkg::PPW'(e_dmag_ff[k])
                             * spi_pkg::PPW'(an_pad[c*spi_pkg::CHW +: spi_pkg::CHW]);
         end
         // G
         g_prod_ff[k] <= spi_pkg::PRODW'(f_pp_ff[k][0])
                         + (spi_pkg::PRODW'(f_pp_ff[k][1]) << spi_pkg::CHW)
                         + (spi_pkg::PRODW'(f_pp_ff[k][2]) << (2*spi_pkg::CHW));
         // H: dividend 2*prod + |den| for round-half-up
         h_num_ff[k] <= (spi_pkg::NW'(g_prod_ff[k]) << 1) + spi_pkg::NW'(g_ad_ff);
      end
      c_num_ff <= spi_pkg::NUMW'(b_pn_ff[0]) + spi_pkg::NUMW'(b_pn_ff[1])
                  + spi_pkg::NUMW'(b_pn_ff[2]);
      c_den_ff <= spi_pkg::NUMW'(b_pd_ff[0]) + spi_pkg::NUMW'(b_pd_ff[1])
                  + spi_pkg::NUMW'(b_pd_ff[2]);
      d_an_ff    <= c_num_ff[spi_pkg::NUMW-1] ? neg_num[spi_pkg::MAGW-1:0]
                                              : c_num_ff[spi_pkg::MAGW-1:0];
      d_ad_ff    <= c_den_ff[spi_pkg::NUMW-1] ? neg_den[spi_pkg::MAGW-1:0]
                                              : c_den_ff[spi_pkg::MAGW-1:0];
      d_nneg_ff  <= c_num_ff[spi_pkg::NUMW-1];
      d_dnz_ff   <= c_den_ff[spi_pkg::NUMW-1];
      d_nzero_ff <= (c_num_ff == '0);
      d_dzero_ff <= (c_den_ff == '0);
      e_hit_ff   <= ~d_dzero_ff & (d_nzero_ff | (d_nneg_ff == d_dnz_ff))
                    & (d_an_ff <= d_ad_ff);
      e_an_ff    <= d_an_ff;
      e_ad_ff    <= d_ad_ff;
      f_side_ff.hit  <= e_hit_ff;
      f_side_ff.dneg <= e_dneg_ff;
      f_side_ff.s    <= e_s_ff;
      f_ad_ff        <= e_ad_ff;
      g_side_ff      <= f_side_ff;
      g_ad_ff        <= f_ad_ff;
      h_side_ff      <= g_side_ff;
      h_den_ff       <= {g_ad_ff, 1'b0};
   end

   spi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (h_vld_ff),
      .in_num    (h_num_ff),
      .in_den    (h_den_ff),
      .in_side   (h_side_ff),
      .out_valid (q_vld),
      .out_quo   (q_quo),
      .out_side  (q_side)
   );

   always_comb begin
      logic signed [spi_pkg::RW-1:0] sum;
      logic signed [spi_pkg::RW-1:0] off;
      for (int k = 0; k < 3; k++) begin
         off = signed'(spi_pkg::RW'(q_quo[k]));
         sum = spi_pkg::RW'(signed'(q_side.s[k]));
         sum = q_side.dneg[k] ? sum - off : sum + off;
         if (!q_side.hit) begin
            point_in[k] = '0;
         end else if (sum > spi_pkg::RW'(signed'({1'b0, {(CW-1){1'b1}}}))) begin
            point_in[k] = {1'b0, {(CW-1){1'b1}}};
         end else if (sum < spi_pkg::RW'(signed'({1'b1, {(CW-1){1'b0}}}))) begin
            point_in[k] = {1'b1, {(CW-1){1'b0}}};
         end else begin
            point_in[k] = sum[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= q_vld;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff   <= q_side.hit;
      point_ff <= point_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_hit     = hit_ff;
   assign rsp_point_x = point_ff[0];
   assign rsp_point_y = point_ff[1];
   assign rsp_point_z = point_ff[2];

endmodule

FILE: design/spi_chk.sv
// Port-level checker for segment_plane_intersect, bound to the top level.
// Depends on spi_pkg.
module spi_chk (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_hit,
   input logic [31:0] rsp_point_x,
   input logic [31:0] rsp_point_y,
   input logic [31:0] rsp_point_z
);

   a_no_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_strobe_has_source : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, spi_pkg::LATENCY))
      else $error("result without a matching transfer");

   a_transfer_gives_result : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(spi_pkg::LATENCY) rsp_strobe)
      else $error("transfer lost");

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_hit) |->
         (rsp_point_x == '0 && rsp_point_y == '0 && rsp_point_z == '0))
      else $error("miss with nonzero point");

endmodule

bind segment_plane_intersect spi_chk u_spi_chk (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_hit     (rsp_hit),
   .rsp_point_x (rsp_point_x),
   .rsp_point_y (rsp_point_y),
   .rsp_point_z (rsp_point_z)
);
